### rtl/rrc_pkg.sv
// Shared types and constants of the request replay cache.
// Depends on nothing; the interfaces, the top level and the testbench import it.
`default_nettype none

package rrc_pkg;

    localparam int unsigned CACHE_ENTRIES_DEF     = 8;
    localparam int unsigned MAX_REQUEST_BYTES_DEF = 1024;
    localparam int unsigned HEADER_BYTES_DEF      = 16;

    localparam int unsigned IP_W    = 32;
    localparam int unsigned PORT_W  = 16;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned OFFS_W  = 32;
    localparam int unsigned LEN_W   = 11;
    localparam int unsigned SLOT_W  = 3;
    localparam int unsigned META_W  = 4;

    // Command word layout.
    localparam int unsigned WRITE_BIT  = 15;
    localparam int unsigned META_SHIFT = 13;

    // Meta length per code, one nibble per code: 0, 2, 4, 8 bytes.
    localparam logic [15:0] META_TABLE = 16'h8420;

    typedef struct packed {
        logic [IP_W-1:0]   src_ip;
        logic [PORT_W-1:0] src_port;
        logic [WORD_W-1:0] request_id;
        logic [WORD_W-1:0] command_word;
        logic [WORD_W-1:0] object_index;
        logic [OFFS_W-1:0] object_offset;
        logic [LEN_W-1:0]  length;
    } key_t;

    localparam int unsigned KEY_W = $bits(key_t);

    function automatic logic [META_W-1:0] meta_decode(input logic [1:0] code);
        logic [META_W-1:0] nib;
        case (code)
            2'd0:    nib = META_TABLE[3:0];
            2'd1:    nib = META_TABLE[7:4];
            2'd2:    nib = META_TABLE[11:8];
            default: nib = META_TABLE[15:12];
        endcase
        return nib;
    endfunction

endpackage

`default_nettype wire

### rtl/rrc_req_if.sv
// Request channel of the request replay cache: valid, ready and one header.
// Depends on rrc_pkg for field widths.
`default_nettype none

interface rrc_req_if;
    import rrc_pkg::*;

    logic              valid;
    logic              ready;
    logic [IP_W-1:0]   src_ip;
    logic [PORT_W-1:0] src_port;
    logic [WORD_W-1:0] request_id;
    logic [WORD_W-1:0] command_word;
    logic [WORD_W-1:0] object_index;
    logic [OFFS_W-1:0] object_offset;
    logic [LEN_W-1:0]  datagram_length;

    modport source (
        output valid, src_ip, src_port, request_id, command_word,
               object_index, object_offset, datagram_length,
        input  ready
    );

    modport sink (
        input  valid, src_ip, src_port, request_id, command_word,
               object_index, object_offset, datagram_length,
        output ready
    );
endinterface

`default_nettype wire

### rtl/rrc_rsp_if.sv
// Result channel of the request replay cache: valid, ready and one result.
// Depends on rrc_pkg for field widths.
`default_nettype none

interface rrc_rsp_if;
    import rrc_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              is_write;
    logic [LEN_W-1:0]  request_length;
    logic [META_W-1:0] meta_length;

    modport source (
        output valid, hit, slot, is_write, request_length, meta_length,
        input  ready
    );

    modport sink (
        input  valid, hit, slot, is_write, request_length, meta_length,
        output ready
    );
endinterface

`default_nettype wire

### rtl/rrc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none

module rrc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/request_replay_cache_top.sv
// Request replay cache top level; depends on rrc_pkg, rrc_req_if, rrc_rsp_if and rrc_ram.
// A miss scans every entry before its result is ready; a hit ends the scan at the first
// matching slot in ascending order. The key memory is read one entry per cycle.
// Throughput: one request at a time; ready returns as the result loads, in the same cycle
// that result valid rises. A stalled result delays that load.
// Reset: asynchronous, active low; clears state, valid bits, replace pointer and result valid.
`default_nettype none

module request_replay_cache_top #(
    parameter int unsigned CACHE_ENTRIES     = rrc_pkg::CACHE_ENTRIES_DEF,
    parameter int unsigned MAX_REQUEST_BYTES = rrc_pkg::MAX_REQUEST_BYTES_DEF,
    parameter int unsigned HEADER_BYTES      = rrc_pkg::HEADER_BYTES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rrc_req_if.sink   req,
    rrc_rsp_if.source rsp
);
    import rrc_pkg::*;

    localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_REQUEST_BYTES);
    localparam logic [LEN_W-1:0] HDR_LEN  = LEN_W'(HEADER_BYTES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [CACHE_ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 issue_done_reg, issue_done_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     slot_idx_reg, slot_idx_next;
    logic                 out_valid_reg, out_valid_next;

    // Request payload, held for the whole scan.
    key_t                 key_reg;
    logic                 wr_reg;
    logic [META_W-1:0]    meta_reg;

    // Result payload.
    logic                 out_hit_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic                 out_wr_reg;
    logic [LEN_W-1:0]     out_len_reg;
    logic [META_W-1:0]    out_meta_reg;

    logic                 accept;
    logic                 load_out;
    logic                 ram_we;
    logic                 ram_re;
    logic [KEY_W-1:0]     ram_rdata;
    key_t                 rd_key;
    logic                 match;

    logic                 in_wr;
    logic [LEN_W-1:0]     dlen_sat;
    logic [LEN_W-1:0]     in_len;

    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    // Command decode on the incoming header.
    always_comb
    begin
        in_wr    = req.command_word[WRITE_BIT];
        dlen_sat = (req.datagram_length > MAX_LEN) ? MAX_LEN : req.datagram_length;
        if (in_wr)
        begin
            in_len = (dlen_sat > HDR_LEN) ? (dlen_sat - HDR_LEN) : '0;
        end
        else
        begin
            in_len = req.command_word[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg.src_ip        <= req.src_ip;
            key_reg.src_port      <= req.src_port;
            key_reg.request_id    <= req.request_id;
            key_reg.command_word  <= req.command_word;
            key_reg.object_index  <= req.object_index;
            key_reg.object_offset <= req.object_offset;
            key_reg.length        <= in_len;
            wr_reg                <= in_wr;
            meta_reg              <= meta_decode(req.command_word[META_SHIFT+1:META_SHIFT]);
        end
        if (load_out)
        begin
            out_hit_reg  <= hit_reg;
            out_slot_reg <= SLOT_W'(slot_idx_reg);
            out_wr_reg   <= wr_reg;
            out_len_reg  <= key_reg.length;
            out_meta_reg <= meta_reg;
        end
    end

    assign rd_key = key_t'(ram_rdata);
    assign match  = valid_reg[cmp_idx_reg] && (rd_key == key_reg);

    // Reads are issued one entry per cycle; each read is compared in the cycle after
    // it is issued, so the first matching slot in ascending order wins. The miss
    // write happens only after the scan, so reads and writes never overlap.
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        ptr_next        = ptr_reg;
        rd_idx_next     = rd_idx_reg;
        issue_done_next = issue_done_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_vld_next    = 1'b0;
        hit_next        = hit_reg;
        slot_idx_next   = slot_idx_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        load_out        = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rd_idx_next     = '0;
                    issue_done_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!issue_done_reg)
                begin
                    ram_re       = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg;
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
                if (cmp_vld_reg)
                begin
                    if (match)
                    begin
                        hit_next      = 1'b1;
                        slot_idx_next = cmp_idx_reg;
                        cmp_vld_next  = 1'b0;
                        state_next    = S_DONE;
                    end
                    else if (cmp_idx_reg == LAST_IDX)
                    begin
                        hit_next      = 1'b0;
                        slot_idx_next = ptr_reg;
                        state_next    = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (!hit_reg)
                    begin
                        ram_we              = 1'b1;
                        valid_next[ptr_reg] = 1'b1;
                        ptr_next = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            ptr_reg        <= '0;
            rd_idx_reg     <= '0;
            issue_done_reg <= 1'b0;
            cmp_idx_reg    <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            slot_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            ptr_reg        <= ptr_next;
            rd_idx_reg     <= rd_idx_next;
            issue_done_reg <= issue_done_next;
            cmp_idx_reg    <= cmp_idx_next;
            cmp_vld_reg    <= cmp_vld_next;
            hit_reg        <= hit_next;
            slot_idx_reg   <= slot_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    rrc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (KEY_W'(key_reg)),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign rsp.valid          = out_valid_reg;
    assign rsp.hit            = out_hit_reg;
    assign rsp.slot           = out_slot_reg;
    assign rsp.is_write       = out_wr_reg;
    assign rsp.request_length = out_len_reg;
    assign rsp.meta_length    = out_meta_reg;

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for request_replay_cache_top: decode of the command word,
// cache hits and FIFO replacement, checked against an in-bench predictor.
// Depends on rrc_pkg, rrc_req_if and rrc_rsp_if from the RTL.
`timescale 1ns / 100ps

module tb;
    import rrc_pkg::*;

    localparam int unsigned ENTRIES        = CACHE_ENTRIES_DEF;
    localparam int unsigned MAX_BYTES      = MAX_REQUEST_BYTES_DEF;
    localparam int unsigned HDR_BYTES      = HEADER_BYTES_DEF;
    localparam int unsigned LATENCY        = ENTRIES + 3;
    localparam int unsigned MAX_IDLE       = 15;
    localparam int unsigned WATCHDOG_LIMIT = 10 * (2 * MAX_IDLE + LATENCY);
    localparam int unsigned HISTORY_DEPTH  = 2 * ENTRIES;

    typedef struct packed {
        logic [IP_W-1:0]   src_ip;
        logic [PORT_W-1:0] src_port;
        logic [WORD_W-1:0] request_id;
        logic [WORD_W-1:0] command_word;
        logic [WORD_W-1:0] object_index;
        logic [OFFS_W-1:0] object_offset;
        logic [LEN_W-1:0]  datagram_length;
    } request_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              is_write;
        logic [LEN_W-1:0]  request_length;
        logic [META_W-1:0] meta_length;
    } lookup_t;

    logic clk;
    logic rst_n;

    rrc_req_if req_ch ();
    rrc_rsp_if rsp_ch ();

    request_replay_cache_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predictor state: a copy of the key store and the replacement pointer.
    bit          entry_valid [ENTRIES];
    key_t        entry_key [ENTRIES];
    int unsigned fill_ptr = 0;

    lookup_t     expected_lookups [$];
    request_t    recent_requests [$];

    bit          idle_enabled = 1'b1;
    int unsigned error_count = 0;
    int unsigned stall_cycles = 0;
    int unsigned requests_accepted = 0;
    int unsigned hits_seen = 0;
    int unsigned misses_seen = 0;
    int unsigned writes_seen = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic lookup_t lookup_request(input request_t r);
        lookup_t          res;
        key_t             key;
        logic [LEN_W-1:0] dlen;
        logic [1:0]       code;
        int unsigned      i;

        res = '0;
        code = r.command_word[META_SHIFT +: 2];
        res.is_write = r.command_word[WRITE_BIT];
        res.meta_length = META_TABLE[code * META_W +: META_W];
        dlen = (r.datagram_length > MAX_BYTES) ? LEN_W'(MAX_BYTES) : r.datagram_length;
        if (res.is_write)
            res.request_length = (dlen > HDR_BYTES) ? LEN_W'(dlen - HDR_BYTES) : '0;
        else
            res.request_length = r.command_word[LEN_W-1:0];

        key.src_ip        = r.src_ip;
        key.src_port      = r.src_port;
        key.request_id    = r.request_id;
        key.command_word  = r.command_word;
        key.object_index  = r.object_index;
        key.object_offset = r.object_offset;
        key.length        = res.request_length;

        // The lowest matching slot wins; invalid slots never match.
        for (i = 0; i < ENTRIES; i++)
        begin
            if (!res.hit && entry_valid[i] && entry_key[i] == key)
            begin
                res.hit = 1'b1;
                res.slot = SLOT_W'(i);
            end
        end
        if (!res.hit)
        begin
            entry_valid[fill_ptr] = 1'b1;
            entry_key[fill_ptr] = key;
            res.slot = SLOT_W'(fill_ptr);
            fill_ptr = (fill_ptr + 1) % ENTRIES;
        end
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] make_command(input logic wr, input logic [1:0] code,
                                                       input logic [LEN_W-1:0] len);
        logic [WORD_W-1:0] cw;
        cw = '0;
        cw[WRITE_BIT] = wr;
        cw[META_SHIFT +: 2] = code;
        cw[LEN_W-1:0] = len;
        return cw;
    endfunction

    function automatic request_t make_request(input logic [IP_W-1:0] ip,
                                              input logic [PORT_W-1:0] port,
                                              input logic [WORD_W-1:0] id,
                                              input logic [WORD_W-1:0] cmd,
                                              input logic [WORD_W-1:0] idx,
                                              input logic [OFFS_W-1:0] offs,
                                              input logic [LEN_W-1:0] dlen);
        request_t r;
        r.src_ip          = ip;
        r.src_port        = port;
        r.request_id      = id;
        r.command_word    = cmd;
        r.object_index    = idx;
        r.object_offset   = offs;
        r.datagram_length = dlen;
        return r;
    endfunction

    function automatic request_t random_request();
        request_t r;
        r.src_ip        = $urandom;
        r.src_port      = PORT_W'($urandom);
        r.request_id    = WORD_W'($urandom);
        r.command_word  = WORD_W'($urandom);
        r.object_index  = WORD_W'($urandom);
        r.object_offset = $urandom;
        case ($urandom_range(0, 7))
            0:       r.datagram_length = LEN_W'($urandom_range(0, HDR_BYTES));
            1:       r.datagram_length = LEN_W'($urandom);
            default: r.datagram_length = LEN_W'($urandom_range(0, MAX_BYTES + HDR_BYTES));
        endcase
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is accepted.
    task automatic send_request(input request_t r);
        if (idle_enabled && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, MAX_IDLE)) @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.src_ip          <= r.src_ip;
        req_ch.src_port        <= r.src_port;
        req_ch.request_id      <= r.request_id;
        req_ch.command_word    <= r.command_word;
        req_ch.object_index    <= r.object_index;
        req_ch.object_offset   <= r.object_offset;
        req_ch.datagram_length <= r.datagram_length;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        recent_requests.push_back(r);
        if (recent_requests.size() > HISTORY_DEPTH)
            void'(recent_requests.pop_front());
    endtask

    // Holds off the sender until every outstanding lookup has returned.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_lookups.size() != 0) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    task automatic test_decode_extremes();
        int unsigned write_lengths [6];
        int unsigned k;

        write_lengths = '{0, HDR_BYTES - 1, HDR_BYTES, HDR_BYTES + 1, MAX_BYTES, MAX_BYTES + 1};
        send_request(make_request('0, '0, '0, make_command(1'b0, 2'd0, '0), '0, '0, '0));
        send_request(make_request('1, '1, '1, '1, '1, '1, '1));
        // Read lengths come from the command word whatever the datagram length.
        send_request(make_request(32'h0A00_0001, 16'd5000, 16'd3,
                                  make_command(1'b0, 2'd1, 11'h7FF), 16'd1, 32'h0, 11'd0));
        send_request(make_request(32'h0A00_0001, 16'd5000, 16'd4,
                                  make_command(1'b0, 2'd2, 11'h400), 16'd2, 32'h1000, 11'h7FF));
        send_request(make_request(32'h0A00_0001, 16'd5000, 16'd5,
                                  make_command(1'b0, 2'd3, 11'd5), 16'd3, 32'h8000_0000,
                                  LEN_W'(MAX_BYTES)));
        // Writes around the header size and the datagram size limit.
        for (k = 0; k < 6; k++)
            send_request(make_request(32'hC0A8_0101, 16'd7000, WORD_W'(6 + k),
                                      make_command(1'b1, 2'(k), 11'd0), WORD_W'(k),
                                      32'h0000_0100, LEN_W'(write_lengths[k])));
    endtask

    task automatic test_replay_hits();
        request_t first_req, read_a, read_b, short_wr, long_wr, r;

        first_req = recent_requests[0];
        read_a    = recent_requests[3];
        read_b    = recent_requests[4];
        short_wr  = recent_requests[6];
        long_wr   = recent_requests[10];

        send_request(long_wr);
        // Both lengths saturate to the same write length, so the key matches.
        r = long_wr;
        r.datagram_length = 11'd1500;
        send_request(r);
        r = short_wr;
        r.datagram_length = 11'd3;
        send_request(r);
        r = read_a;
        r.datagram_length = 11'd77;
        send_request(r);
        // The oldest entry has been replaced by now.
        send_request(first_req);
        send_request(read_b);
        r = read_b;
        r.request_id = r.request_id + 1'b1;
        send_request(r);
        drain_results();
    endtask

    task automatic test_random_traffic(input int unsigned count, input bit with_idle);
        request_t    r;
        int unsigned pick;
        int unsigned k;

        idle_enabled = with_idle;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (recent_requests.size() == 0 || pick < 40)
            begin
                r = random_request();
            end
            else
            begin
                // Repeat a recent request, often with a datagram length that leaves the key
                // unchanged, or with one bit flipped for a near miss.
                r = recent_requests[$urandom_range(0, recent_requests.size() - 1)];
                if (pick < 85)
                begin
                    if (!r.command_word[WRITE_BIT])
                        r.datagram_length = LEN_W'($urandom);
                    else if (r.datagram_length >= MAX_BYTES)
                        r.datagram_length = LEN_W'($urandom_range(MAX_BYTES, (1 << LEN_W) - 1));
                    else if (r.datagram_length <= HDR_BYTES)
                        r.datagram_length = LEN_W'($urandom_range(0, HDR_BYTES));
                end
                else
                begin
                    r[$urandom_range(0, $bits(request_t) - 1)] ^= 1'b1;
                end
            end
            send_request(r);
            if (k % 300 == 299)
                drain_results();
        end
    endtask

    initial
    begin
        int unsigned span;
        rsp_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (idle_enabled && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                span = $urandom_range(1, MAX_IDLE);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                span = $urandom_range(1, 20);
            end
            repeat (span) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        lookup_t  want;
        request_t seen;
        bit       moved;

        if (rst_n)
        begin
            moved = 1'b0;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved = 1'b1;
                if (expected_lookups.size() == 0)
                begin
                    $error("result transaction with no request outstanding");
                    error_count++;
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    check_field("hit", 32'(want.hit), 32'(rsp_ch.hit));
                    check_field("slot", 32'(want.slot), 32'(rsp_ch.slot));
                    check_field("is_write", 32'(want.is_write), 32'(rsp_ch.is_write));
                    check_field("request_length", 32'(want.request_length),
                                32'(rsp_ch.request_length));
                    check_field("meta_length", 32'(want.meta_length),
                                32'(rsp_ch.meta_length));
                    if (want.hit)
                        hits_seen++;
                    else
                        misses_seen++;
                    if (want.is_write)
                        writes_seen++;
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                moved = 1'b1;
                seen = make_request(req_ch.src_ip, req_ch.src_port, req_ch.request_id,
                                    req_ch.command_word, req_ch.object_index,
                                    req_ch.object_offset, req_ch.datagram_length);
                expected_lookups.push_back(lookup_request(seen));
                requests_accepted++;
            end
            if (moved)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid           <= 1'b0;
        req_ch.src_ip          <= '0;
        req_ch.src_port        <= '0;
        req_ch.request_id      <= '0;
        req_ch.command_word    <= '0;
        req_ch.object_index    <= '0;
        req_ch.object_offset   <= '0;
        req_ch.datagram_length <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_decode_extremes();
        test_replay_hits();
        test_random_traffic(1200, 1'b1);
        test_random_traffic(150, 1'b0);
        drain_results();
        // Leave room for any stray result transaction to show up.
        repeat (4 * LATENCY) @(posedge clk);

        $display("Checked %0d lookups: %0d replays of cached requests, %0d new allocations,",
                 requests_accepted, hits_seen, misses_seen);
        $display("%0d writes; both channels stalled in random bursts, then ran back to back.",
                 writes_seen);
        if (error_count == 0 && expected_lookups.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/rrc_pkg.sv
rtl/rrc_req_if.sv
rtl/rrc_rsp_if.sv
rtl/rrc_ram.sv
rtl/request_replay_cache_top.sv
sim/tb.sv
